// ===== hdl/ldist_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Legendre distribution core.
`timescale 1ns / 1ps
package ldist_pkg;

    localparam int COEF_W   = 32;
    localparam int ENERGY_W = 25;
    localparam int ORDER_W  = 6;
    localparam int ANGLE_W  = 12;
    localparam int PROB_W   = 48;
    localparam int ACC_W    = 50;
    localparam int DVD_W    = 60;
    localparam int DVS_W    = 25;
    localparam int CNT_W    = 6;
    localparam int COS_DEPTH = 1441;
    localparam int COS_AW    = 11;

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;
    localparam logic signed [31:0] ONE_Q30 = 32'sh40000000;
    localparam logic [11:0] HALF_TURN = 12'd2880;
    localparam logic [11:0] QUARTER_TURN = 12'd1440;

    typedef enum logic [1:0] {
        REG_ENERGY_LOW    = 2'd0,
        REG_ENERGY_HIGH   = 2'd1,
        REG_ENERGY_TARGET = 2'd2,
        REG_ORDER_COUNT   = 2'd3
    } reg_index_t;

    typedef logic [30:0] cos_rom_t [0:COS_DEPTH-1];

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    // Round-to-nearest (ties away from zero) of x / 2^30.
    function automatic logic signed [33:0] rnd30(input logic signed [63:0] x);
        logic [63:0] mag;
        logic [63:0] q;
        mag = x[63] ? 64'(-x) : 64'(x);
        q   = (mag + 64'd536870912) >> 30;
        return x[63] ? -$signed(q[33:0]) : $signed(q[33:0]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // First-quadrant cosine table, Q1.30 magnitude, built by Taylor series.
    function automatic cos_rom_t cos_rom_build();
        cos_rom_t           t;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [127:0]       p;
        logic signed [63:0] sum;
        logic [63:0]        c;
        int                 b;
        int                 k;
        for (b = 0; b < COS_DEPTH; b++) begin
            x = (PI_Q60 / 64'd2880) * 64'(b) + ((PI_Q60 % 64'd2880) * 64'(b)) / 64'd2880;
            p = 128'(x) * 128'(x);
            x2 = p[123:60];
            term = ONE_Q60;
            sum = $signed(term);
            for (k = 1; k <= 14; k++) begin
                p = 128'(term) * 128'(x2);
                term = p[123:60] / 64'((2 * k - 1) * (2 * k));
                if ((k % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) sum = 64'sd0;
            if (sum > $signed(ONE_Q60)) sum = $signed(ONE_Q60);
            c = (64'(sum) + 64'd536870912) >> 30;
            t[b] = c[30:0];
        end
        return t;
    endfunction

endpackage

// ===== hdl/legendre_angular_distribution_core.sv =====
// Top level: Legendre series angular distribution evaluator with APB configuration.
`timescale 1ns / 1ps
// Usage
//  - Input channel (s_*): opcode 0 loads coefficient slot order_index, interpolated
//    in energy from coef_low/coef_high to energy_target; opcode 1 evaluates the
//    density at angle (1/16 degree). Loads return no item.
//  - Result channel (m_*): one item per evaluate: probability (Q17.30, clamped),
//    angle_out echo and the saturated flag.
//  - APB port: energy_low at 0x0, energy_high at 0x4, energy_target at 0x8,
//    order_count at 0xC. Write only while the core is idle.
// Sequencing
//  - One item at a time; s_ready is high only when the sequencer is idle.
//  - Load: one 33x26 multiply, then the 60-step divider; equal bracket
//    energies skip the divider.
//  - Evaluate: n = min(order_count, MAX_ORDERS) orders. Each order runs two
//    shared 32x32 multiplies and one pass through the shared bit-serial divider.
// Reset clears the sequencer, the result valid and the configuration registers. The table
// is not cleared: only slots that have been loaded may be evaluated.
// A stalled result sits in the output register; the next item is still taken,
// and its evaluate waits at the end for that register to drain.
module legendre_angular_distribution_core #(
    parameter int MAX_ORDERS = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // APB configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [3:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // input items
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_opcode,
    input  logic [4:0]                            s_order_index,
    input  logic signed [ldist_pkg::COEF_W-1:0]   s_coef_low,
    input  logic signed [ldist_pkg::COEF_W-1:0]   s_coef_high,
    input  logic [ldist_pkg::ANGLE_W-1:0]         s_angle,
    // result items
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ldist_pkg::PROB_W-1:0]   m_probability,
    output logic [ldist_pkg::ANGLE_W-1:0]         m_angle_out,
    output logic                                  m_saturated
);
    import ldist_pkg::*;

    localparam int AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int JW = $clog2(MAX_ORDERS + 1);
    localparam logic signed [ACC_W:0] PMAX = (ACC_W + 1)'(48'sh7FFFFFFFFFFF);
    localparam logic signed [ACC_W:0] PMIN = -PMAX - 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LMUL, ST_LDIV, ST_LWAIT,
        ST_ECOS, ST_EMU, ST_EMULMU, ST_EMULC, ST_EACC, ST_EDIV, ST_EWAIT, ST_EDONE
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [ENERGY_W-1:0] e_low_reg, e_high_reg, e_tgt_reg;
    logic [ORDER_W-1:0]  order_cnt_reg;

    // item registers
    logic [4:0]               idx_reg;
    logic signed [COEF_W-1:0] y1_reg, y2_reg;
    logic [ANGLE_W-1:0]       angle_reg;

    // datapath registers
    logic signed [63:0]       prod_reg;
    logic signed [25:0]       den_reg;
    logic                     neg_reg;
    logic signed [COEF_W-1:0] mu_reg, p_prev_reg, p_cur_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [33:0]       r_reg;
    logic signed [43:0]       ta_reg, tb_reg;
    logic [JW-1:0]            j_reg, n_reg;

    // result registers
    logic                     m_valid_reg;
    logic signed [PROB_W-1:0] prob_reg;
    logic [ANGLE_W-1:0]       angle_out_reg;
    logic                     sat_reg;

    // sub-unit wiring
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;
    logic signed [COEF_W-1:0] mu_rom;
    logic signed [COEF_W-1:0] coef_rdata;
    logic                     mem_we;
    logic signed [COEF_W-1:0] mem_wdata;

    // combinational helpers
    logic                     accept;
    logic                     idx_ok;
    logic signed [32:0]       dy;
    logic signed [25:0]       de;
    logic [24:0]              den_abs;
    logic [63:0]              prod_abs;
    logic signed [63:0]       interp;
    logic [7:0]               ord8;
    logic [7:0]               k8;
    logic signed [COEF_W-1:0] mul_a;
    logic signed [33:0]       cp;
    logic signed [43:0]       num;
    logic signed [63:0]       nxt_wide;
    logic [ACC_W-1:0]         acc_abs;
    logic [ACC_W-1:0]         half_abs;
    logic signed [ACC_W:0]    prob_full;
    logic [JW-1:0]            n_clamp;
    logic                     out_free;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign idx_ok   = int'(idx_reg) < MAX_ORDERS;

    // APB
    assign pready = 1'b1;
    always_comb begin
        unique case (reg_index_t'(paddr[3:2]))
            REG_ENERGY_LOW:    prdata = 32'(e_low_reg);
            REG_ENERGY_HIGH:   prdata = 32'(e_high_reg);
            REG_ENERGY_TARGET: prdata = 32'(e_tgt_reg);
            REG_ORDER_COUNT:   prdata = 32'(order_cnt_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        n_clamp = (int'(order_cnt_reg) > MAX_ORDERS) ? JW'(MAX_ORDERS) : JW'(order_cnt_reg);
        dy      = $signed({y2_reg[31], y2_reg}) - $signed({y1_reg[31], y1_reg});
        de      = $signed({1'b0, e_tgt_reg}) - $signed({1'b0, e_low_reg});
        den_abs = den_reg[25] ? 25'(-den_reg) : 25'(den_reg);
        prod_abs = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
        interp  = 64'(y1_reg) + (neg_reg ? -$signed(64'(div_rsp.quotient))
                                         : $signed(64'(div_rsp.quotient)));
        ord8    = 8'(j_reg) + 8'd1;
        k8      = {ord8[6:0], 1'b1};
        mul_a   = (state_reg == ST_EMULMU) ? mu_reg : coef_rdata;
        cp      = rnd30(prod_reg);
        num     = ta_reg - tb_reg;
        nxt_wide = neg_reg ? -$signed(64'(div_rsp.quotient)) : $signed(64'(div_rsp.quotient));
        acc_abs  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        half_abs = (acc_abs + 1'b1) >> 1;
        prob_full = acc_reg[ACC_W-1] ? -$signed({1'b0, half_abs}) : $signed({1'b0, half_abs});
    end

    // divider requests
    always_comb begin
        div_req = '0;
        if (state_reg == ST_LDIV) begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'(prod_abs + 64'(den_abs >> 1));
            div_req.divisor  = den_abs;
        end else if (state_reg == ST_EDIV) begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'(num[43] ? 44'(-num) : 44'(num)) + DVD_W'((ord8 + 8'd1) >> 1);
            div_req.divisor  = DVS_W'(ord8 + 8'd1);
        end
    end

    // table write: direct copy for equal energies, else the interpolated value
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = y1_reg;
        if (state_reg == ST_LMUL && den_reg == '0) begin
            mem_we = idx_ok;
        end else if (state_reg == ST_LWAIT && div_rsp.done) begin
            mem_we    = idx_ok;
            mem_wdata = sat32(interp);
        end
    end

    ldist_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    ldist_cos_rom u_cos (
        .aclk  (aclk),
        .angle (angle_reg),
        .mu    (mu_rom)
    );

    ldist_coef_mem #(
        .DEPTH (MAX_ORDERS),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (AW'(idx_reg)),
        .wdata (mem_wdata),
        .raddr (j_reg[AW-1:0]),
        .rdata (coef_rdata)
    );

    // sequencer, datapath and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            e_low_reg     <= '0;
            e_high_reg    <= '0;
            e_tgt_reg     <= '0;
            order_cnt_reg <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (reg_index_t'(paddr[3:2]))
                    REG_ENERGY_LOW:    e_low_reg     <= pwdata[ENERGY_W-1:0];
                    REG_ENERGY_HIGH:   e_high_reg    <= pwdata[ENERGY_W-1:0];
                    REG_ENERGY_TARGET: e_tgt_reg     <= pwdata[ENERGY_W-1:0];
                    REG_ORDER_COUNT:   order_cnt_reg <= pwdata[ORDER_W-1:0];
                    default: ;
                endcase
            end
            // the done state reloads the result register itself
            if (m_valid_reg && m_ready && state_reg != ST_EDONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        idx_reg   <= s_order_index;
                        y1_reg    <= s_coef_low;
                        y2_reg    <= s_coef_high;
                        angle_reg <= s_angle;
                        den_reg   <= $signed({1'b0, e_high_reg}) - $signed({1'b0, e_low_reg});
                        state_reg <= s_opcode ? ST_ECOS : ST_LMUL;
                    end
                end
                ST_LMUL: begin
                    prod_reg  <= 64'(dy * de);
                    if (den_reg == '0) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_LDIV;
                    end
                end
                ST_LDIV: begin
                    neg_reg   <= prod_reg[63] ^ den_reg[25];
                    state_reg <= ST_LWAIT;
                end
                ST_LWAIT: begin
                    if (div_rsp.done) state_reg <= ST_IDLE;
                end
                ST_ECOS: begin
                    state_reg <= ST_EMU;
                end
                ST_EMU: begin
                    mu_reg     <= mu_rom;
                    p_prev_reg <= ONE_Q30;
                    p_cur_reg  <= mu_rom;
                    acc_reg    <= ACC_W'(ONE_Q30);
                    j_reg      <= '0;
                    n_reg      <= n_clamp;
                    state_reg  <= (n_clamp == '0) ? ST_EDONE : ST_EMULMU;
                end
                ST_EMULMU: begin
                    prod_reg  <= mul_a * p_cur_reg;
                    state_reg <= ST_EMULC;
                end
                ST_EMULC: begin
                    r_reg     <= rnd30(prod_reg);
                    prod_reg  <= mul_a * p_cur_reg;
                    state_reg <= ST_EACC;
                end
                ST_EACC: begin
                    acc_reg   <= acc_reg + ACC_W'($signed({1'b0, k8}) * cp);
                    ta_reg    <= 44'($signed({1'b0, k8}) * r_reg);
                    tb_reg    <= 44'($signed({1'b0, ord8}) * p_prev_reg);
                    state_reg <= ST_EDIV;
                end
                ST_EDIV: begin
                    neg_reg   <= num[43];
                    state_reg <= ST_EWAIT;
                end
                ST_EWAIT: begin
                    if (div_rsp.done) begin
                        p_prev_reg <= p_cur_reg;
                        p_cur_reg  <= sat32(nxt_wide);
                        j_reg      <= j_reg + 1'b1;
                        state_reg  <= (j_reg + 1'b1 == n_reg) ? ST_EDONE : ST_EMULMU;
                    end
                end
                ST_EDONE: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        angle_out_reg <= angle_reg;
                        if (prob_full > PMAX) begin
                            prob_reg <= PMAX[PROB_W-1:0];
                            sat_reg  <= 1'b1;
                        end else if (prob_full < PMIN) begin
                            prob_reg <= PMIN[PROB_W-1:0];
                            sat_reg  <= 1'b1;
                        end else begin
                            prob_reg <= prob_full[PROB_W-1:0];
                            sat_reg  <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_probability = prob_reg;
    assign m_angle_out   = angle_out_reg;
    assign m_saturated   = sat_reg;

    // the shared divider is never left running while the core takes items
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while sequencer idle");

    // a divider result only lands in a state that consumes it
    a_done_use: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_LWAIT || state_reg == ST_EWAIT))
        else $error("divider result dropped");

    // a clamped result sits exactly on a rail
    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && sat_reg) |->
            (prob_reg == PMAX[PROB_W-1:0] || prob_reg == PMIN[PROB_W-1:0]))
        else $error("saturated flag without clamp");

    // table writes only happen on the load path
    a_we_load: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_LMUL || state_reg == ST_LWAIT))
        else $error("table write outside load");

endmodule

// ===== hdl/ldist_cos_rom.sv =====
// Cosine ROM with quadrant folding and a registered read.
`timescale 1ns / 1ps
module ldist_cos_rom (
    input  logic                                  aclk,
    input  logic [ldist_pkg::ANGLE_W-1:0]         angle,
    output logic signed [ldist_pkg::COEF_W-1:0]   mu
);
    import ldist_pkg::*;

    localparam cos_rom_t COS_TAB = cos_rom_build();

    logic [ANGLE_W-1:0] b_half;
    logic [ANGLE_W-1:0] b_fold;
    logic               neg_half;
    logic               neg_fold;
    logic [30:0]        mag_reg;
    logic               neg_reg;

    always_comb begin
        neg_half = angle > HALF_TURN;
        b_half   = neg_half ? angle - HALF_TURN : angle;
        neg_fold = b_half > QUARTER_TURN;
        b_fold   = neg_fold ? HALF_TURN - b_half : b_half;
    end

    always_ff @(posedge aclk) begin
        mag_reg <= COS_TAB[b_fold[COS_AW-1:0]];
        neg_reg <= neg_half ^ neg_fold;
    end

    assign mu = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

// ===== hdl/ldist_coef_mem.sv =====
// Coefficient store: one write port, one registered read port.
`timescale 1ns / 1ps
module ldist_coef_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [AW-1:0]                       waddr,
    input  logic signed [ldist_pkg::COEF_W-1:0] wdata,
    input  logic [AW-1:0]                       raddr,
    output logic signed [ldist_pkg::COEF_W-1:0] rdata
);
    import ldist_pkg::*;

    logic signed [COEF_W-1:0] mem [0:DEPTH-1];
    logic signed [COEF_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ldist_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ldist_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ldist_pkg::div_req_t   req,
    output ldist_pkg::div_rsp_t   rsp
);
    import ldist_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W:0]   rem_sh;
    logic             fits;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg, dvd_reg[DVD_W-1]};
        fits      = rem_sh >= {1'b0, dvs_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = fits ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule
